@@ design/tpc_pkg.sv @@
// Package for the temperature/pressure compensation block.
// Holds the coefficient, inter-module word types and fixed-point helpers.
// No dependencies.
package tpc_pkg;

  localparam int unsigned NumRegs  = 4;
  localparam int unsigned RegWidth = 48;
  localparam int unsigned DivSteps = 32;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } tpc_coef_t;

  // word handed from the front datapath to the divider
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] dividend;
    logic [31:0] divisor;
    logic        dbl;
    logic        zero;
  } tpc_mid_t;

  // word handed from the divider to the back end
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] quot;
    logic        dbl;
    logic        zero;
  } tpc_quo_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] pres;
    logic        zero;
  } tpc_res_t;

  // signed divide by 2^k, truncating toward zero, 32-bit two's complement
  function automatic logic [31:0] sdiv2(input logic [31:0] x, input int unsigned k);
    logic [31:0] bias;
    logic [31:0] s;
    bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    s = x + bias;
    return 32'($signed(s) >>> k);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] zext16(input logic [15:0] v);
    return {16'd0, v};
  endfunction

endpackage

@@ design/tpc_if.sv @@
// Channel interfaces for the compensation block: raw reading pair in,
// compensated result out. Valid/ready handshake. No dependencies.
interface tpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface tpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] temperature_centi;
  logic [31:0] pressure_pascal;
  logic        divisor_zero;

  modport source (output valid, output temperature_centi, output pressure_pascal,
                  output divisor_zero, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_pascal,
                  input divisor_zero, output ready);
endinterface

@@ design/temp_pressure_compensation.sv @@
// Top level of the temperature/pressure compensation block.
// Depends on tpc_pkg, tpc_if, tpc_front, tpc_div and tpc_post.
//
// Usage:
//   in_word  carries one raw 20-bit temperature and pressure pair per word.
//   out_word carries temperature in 0.01 degC, pressure in Pa and a flag
//            that is set (pressure 0) when the pressure scale factor is zero.
//   cfg_*    writes one of four 48-bit calibration registers per cycle;
//            write only while no word is in flight.
// Pipeline: 10 front stages, 33 divider stages, 3 back-end stages.
// Throughput: one word per cycle while out_word is not stalled; the 33-stage
//   divider pipeline sets the depth, every stage is fully pipelined.
// Reset: rst_n (synchronous, active low) clears all valid bits and the
//   calibration registers.
// Stall: while out_word is valid and not taken, the whole pipeline holds
//   and in_word.ready is low; no word is lost or repeated.
module temp_pressure_compensation (
  input  logic       clk,
  input  logic       rst_n,
  tpc_in_if.sink     in_word,
  tpc_out_if.source  out_word,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [47:0] cfg_wdata
);
  import tpc_pkg::*;

  logic [RegWidth-1:0] coef_r [0:NumRegs-1];
  tpc_coef_t coef;
  logic      en;
  logic      mid_valid, quo_valid, res_valid;
  tpc_mid_t  mid;
  tpc_quo_t  quo;
  tpc_res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  assign coef.t1 = coef_r[0][15:0];
  assign coef.t2 = coef_r[0][31:16];
  assign coef.t3 = coef_r[0][47:32];
  assign coef.p1 = coef_r[1][15:0];
  assign coef.p2 = coef_r[1][31:16];
  assign coef.p3 = coef_r[1][47:32];
  assign coef.p4 = coef_r[2][15:0];
  assign coef.p5 = coef_r[2][31:16];
  assign coef.p6 = coef_r[2][47:32];
  assign coef.p7 = coef_r[3][15:0];
  assign coef.p8 = coef_r[3][31:16];
  assign coef.p9 = coef_r[3][47:32];

  assign en            = !res_valid || out_word.ready;
  assign in_word.ready = en;

  tpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_word.valid),
    .raw_t     (in_word.raw_temperature),
    .raw_p     (in_word.raw_pressure),
    .coef      (coef),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  tpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .mid_valid (mid_valid),
    .mid       (mid),
    .quo_valid (quo_valid),
    .quo       (quo)
  );

  tpc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .quo_valid (quo_valid),
    .quo       (quo),
    .coef      (coef),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_word.valid             = res_valid;
  assign out_word.temperature_centi = res.temp;
  assign out_word.pressure_pascal   = res.pres;
  assign out_word.divisor_zero      = res.zero;

  a_zero_forces_pres: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.divisor_zero |-> out_word.pressure_pascal == 32'd0)
    else $error("divisor_zero set with nonzero pressure");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && !out_word.ready |-> !in_word.ready)
    else $error("input accepted while output stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_word.valid)
    else $error("output valid right after reset");

endmodule

@@ design/tpc_front.sv @@
// Front datapath: temperature, fine temperature and pressure terms up to
// the divider operands, ten register stages. Depends on tpc_pkg.
module tpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [19:0]         raw_t,
  input  logic [19:0]         raw_p,
  input  tpc_pkg::tpc_coef_t  coef,
  output logic                mid_valid,
  output tpc_pkg::tpc_mid_t   mid
);
  import tpc_pkg::*;

  logic [10:1] v_r;

  logic [31:0] x1_r, d_r;
  logic [19:0] up1_r, up2_r, up3_r, up4_r, up5_r, up6_r, up7_r, up8_r;
  logic [31:0] m1_r, dd_r;
  logic [31:0] a3_r, m2_r;
  logic [31:0] fine_r;
  logic [31:0] tm_r, pa5_r;
  logic [31:0] temp6_r, temp7_r, temp8_r, temp9_r, temp10_r;
  logic [31:0] pa6_r, q6_r, ap5_6_r;
  logic [31:0] b0_r, ap5_7_r, pq_r, p2a_r;
  logic [31:0] b8_r, ax_r;
  logic [31:0] am_r, pr_r;
  logic [31:0] a10_r, pres10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[9:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // S1
      x1_r  <= {15'd0, raw_t[19:3]} - (zext16(coef.t1) << 1);
      d_r   <= {16'd0, raw_t[19:4]} - zext16(coef.t1);
      up1_r <= raw_p;
      // S2
      m1_r  <= x1_r * sext16(coef.t2);
      dd_r  <= d_r * d_r;
      up2_r <= up1_r;
      // S3
      a3_r  <= sdiv2(m1_r, 11);
      m2_r  <= sdiv2(dd_r, 12) * sext16(coef.t3);
      up3_r <= up2_r;
      // S4
      fine_r <= a3_r + sdiv2(m2_r, 14);
      up4_r  <= up3_r;
      // S5
      tm_r   <= fine_r * 32'd5;
      pa5_r  <= sdiv2(fine_r, 1) - 32'd64000;
      up5_r  <= up4_r;
      // S6
      temp6_r <= sdiv2(tm_r + 32'd128, 8);
      pa6_r   <= pa5_r;
      q6_r    <= sdiv2(pa5_r, 2) * sdiv2(pa5_r, 2);
      ap5_6_r <= pa5_r * sext16(coef.p5);
      up6_r   <= up5_r;
      // S7
      b0_r    <= sdiv2(q6_r, 11) * sext16(coef.p6);
      pq_r    <= sext16(coef.p3) * sdiv2(q6_r, 13);
      p2a_r   <= sext16(coef.p2) * pa6_r;
      ap5_7_r <= ap5_6_r;
      temp7_r <= temp6_r;
      up7_r   <= up6_r;
      // S8
      b8_r    <= sdiv2(b0_r + (ap5_7_r << 1), 2) + (sext16(coef.p4) << 16);
      ax_r    <= sdiv2(sdiv2(pq_r, 3) + sdiv2(p2a_r, 1), 18);
      temp8_r <= temp7_r;
      up8_r   <= up7_r;
      // S9
      am_r    <= (32'd32768 + ax_r) * zext16(coef.p1);
      pr_r    <= (32'd1048576 - {12'd0, up8_r}) - sdiv2(b8_r, 12);
      temp9_r <= temp8_r;
      // S10
      a10_r    <= sdiv2(am_r, 15);
      pres10_r <= pr_r * 32'd3125;
      temp10_r <= temp9_r;
    end
  end

  assign mid_valid    = v_r[10];
  assign mid.temp     = temp10_r;
  assign mid.dbl      = pres10_r[31];
  assign mid.dividend = pres10_r[31] ? pres10_r : (pres10_r << 1);
  assign mid.divisor  = a10_r;
  assign mid.zero     = (a10_r == 32'd0);

endmodule

@@ design/tpc_div.sv @@
// Pipelined restoring unsigned 32/32 divider, one quotient bit per stage,
// carrying the temperature and flags alongside. Depends on tpc_pkg.
module tpc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               mid_valid,
  input  tpc_pkg::tpc_mid_t  mid,
  output logic               quo_valid,
  output tpc_pkg::tpc_quo_t  quo
);
  import tpc_pkg::*;

  logic [DivSteps:0] v_r;
  logic [31:0]       rem_r  [0:DivSteps];
  logic [31:0]       nq_r   [0:DivSteps];
  logic [31:0]       dv_r   [0:DivSteps];
  logic [31:0]       temp_r [0:DivSteps];
  logic [DivSteps:0] dbl_r;
  logic [DivSteps:0] zero_r;

  logic [31:0] rem_nxt [1:DivSteps];
  logic [31:0] nq_nxt  [1:DivSteps];

  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      logic [33:0] diff;
      diff = {1'b0, rem_r[k], nq_r[k][31]} - {2'b0, dv_r[k]};
      if (!diff[33]) begin
        rem_nxt[k+1] = diff[31:0];
        nq_nxt[k+1]  = {nq_r[k][30:0], 1'b1};
      end else begin
        rem_nxt[k+1] = {rem_r[k][30:0], nq_r[k][31]};
        nq_nxt[k+1]  = {nq_r[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DivSteps-1:0], mid_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= 32'd0;
      nq_r[0]   <= mid.dividend;
      dv_r[0]   <= mid.divisor;
      temp_r[0] <= mid.temp;
      dbl_r[0]  <= mid.dbl;
      zero_r[0] <= mid.zero;
      for (int k = 1; k <= DivSteps; k++) begin
        rem_r[k]  <= rem_nxt[k];
        nq_r[k]   <= nq_nxt[k];
        dv_r[k]   <= dv_r[k-1];
        temp_r[k] <= temp_r[k-1];
        dbl_r[k]  <= dbl_r[k-1];
        zero_r[k] <= zero_r[k-1];
      end
    end
  end

  assign quo_valid = v_r[DivSteps];
  assign quo.temp  = temp_r[DivSteps];
  assign quo.quot  = nq_r[DivSteps];
  assign quo.dbl   = dbl_r[DivSteps];
  assign quo.zero  = zero_r[DivSteps];

endmodule

@@ design/tpc_post.sv @@
// Back end: pressure correction terms after the divide, three register
// stages ending in the output register. Depends on tpc_pkg.
module tpc_post (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               quo_valid,
  input  tpc_pkg::tpc_quo_t  quo,
  input  tpc_pkg::tpc_coef_t coef,
  output logic               res_valid,
  output tpc_pkg::tpc_res_t  res
);
  import tpc_pkg::*;

  logic [3:1]  v_r;
  logic [31:0] p1_r, p2_r;
  logic [31:0] sq_r, mb_r;
  logic [31:0] am_r, bb_r;
  logic [31:0] temp1_r, temp2_r;
  logic        zero1_r, zero2_r;
  tpc_res_t    res_r;
  logic [31:0] pq;

  assign pq = quo.dbl ? (quo.quot << 1) : quo.quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:1], quo_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= pq;
      sq_r    <= (pq >> 3) * (pq >> 3);
      mb_r    <= (pq >> 2) * sext16(coef.p8);
      temp1_r <= quo.temp;
      zero1_r <= quo.zero;

      p2_r    <= p1_r;
      am_r    <= sext16(coef.p9) * {13'd0, sq_r[31:13]};
      bb_r    <= sdiv2(mb_r, 13);
      temp2_r <= temp1_r;
      zero2_r <= zero1_r;

      res_r.temp <= temp2_r;
      res_r.zero <= zero2_r;
      res_r.pres <= zero2_r ? 32'd0
                  : p2_r + sdiv2(sdiv2(am_r, 12) + bb_r + sext16(coef.p7), 4);
    end
  end

  assign res_valid = v_r[3];
  assign res       = res_r;

endmodule

@@ dv/temp_pressure_compensation_tb.sv @@
// Testbench for temp_pressure_compensation: drives raw reading pairs and
// calibration writes, predicts each result with an integer model of the
// compensation and checks every word in order. Depends on tpc_pkg and tpc_if.
`timescale 1ns / 1ps

module temp_pressure_compensation_tb;
  import tpc_pkg::*;

  localparam int unsigned Latency  = 46;

  localparam logic [1:0] RegTemp  = 2'd0;
  localparam logic [1:0] RegPres1 = 2'd1;
  localparam logic [1:0] RegPres2 = 2'd2;
  localparam logic [1:0] RegPres3 = 2'd3;

  typedef struct packed {
    logic [31:0] temperature;
    logic [31:0] pressure;
    logic        zero;
  } comp_word_t;

  class comp_scoreboard;
    logic [47:0] coef[4];
    comp_word_t  pending[$];
    int          mismatches;

    function void write_coef(logic [1:0] idx, logic [47:0] v);
      coef[idx] = v;
    endfunction

    function int signed sf(logic [1:0] r, int pos);
      logic [15:0] v;
      v = coef[r][pos +: 16];
      return int'($signed(v));
    endfunction

    function comp_word_t compensate(logic [19:0] ut_raw, logic [19:0] up_raw);
      int signed t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      int signed ut, a, b, d, fine, q;
      int unsigned pres;
      comp_word_t w;
      t1 = int'(coef[RegTemp][15:0]);
      t2 = sf(RegTemp, 16);  t3 = sf(RegTemp, 32);
      p1 = int'(coef[RegPres1][15:0]);
      p2 = sf(RegPres1, 16); p3 = sf(RegPres1, 32);
      p4 = sf(RegPres2, 0);  p5 = sf(RegPres2, 16); p6 = sf(RegPres2, 32);
      p7 = sf(RegPres3, 0);  p8 = sf(RegPres3, 16); p9 = sf(RegPres3, 32);
      ut = int'({12'd0, ut_raw});
      a = ((ut / 8 - t1 * 2) * t2) / 2048;
      d = ut / 16 - t1;
      b = (((d * d) / 4096) * t3) / 16384;
      fine = a + b;
      w.temperature = (fine * 5 + 128) / 256;
      a = fine / 2 - 64000;
      q = (a / 4) * (a / 4);
      b = (q / 2048) * p6;
      b = b + a * p5 * 2;
      b = b / 4 + p4 * 65536;
      a = ((p3 * (q / 8192)) / 8 + (p2 * a) / 2) / 262144;
      a = ((32768 + a) * p1) / 32768;
      pres = int'(1048576 - int'({12'd0, up_raw})) - b / 4096;
      pres = pres * 3125;
      w.zero = (a == 0);
      if (!w.zero) begin
        if (pres < 32'h8000_0000) pres = (pres << 1) / int'(unsigned'(a));
        else pres = (pres / int'(unsigned'(a))) * 2;
        a = (p9 * int'(((pres / 8) * (pres / 8)) / 8192)) / 4096;
        b = (int'(pres / 4) * p8) / 8192;
        // signed correction term, kept apart from the unsigned sum
        a = (a + b + p7) / 16;
        pres = pres + a;
      end else begin
        pres = 0;
      end
      w.pressure = pres;
      return w;
    endfunction

    function void note_input(logic [19:0] ut, logic [19:0] up);
      pending.push_back(compensate(ut, up));
    endfunction

    function void check_result(comp_word_t got);
      comp_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: temp exp %0d got %0d, pres exp %0d got %0d, zero exp %b got %b",
                   $signed(exp_w.temperature), $signed(got.temperature),
                   exp_w.pressure, got.pressure, exp_w.zero, got.zero);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_wdata = '0;
  bit hold_long = 1'b0;
  bit rand_in = 1'b1;

  tpc_in_if  in_word();
  tpc_out_if out_word();

  comp_scoreboard sb = new();

  temp_pressure_compensation dut (
    .clk(clk), .rst_n(rst_n), .in_word(in_word.sink), .out_word(out_word.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    in_word.valid = 1'b0;
    in_word.raw_temperature = '0;
    in_word.raw_pressure = '0;
    out_word.ready = 1'b0;
    for (int i = 0; i < 4; i++) sb.coef[i] = '0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // receiver side
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_word.valid && out_word.ready)
        sb.check_result({out_word.temperature_centi, out_word.pressure_pascal,
                         out_word.divisor_zero});
    end
  end

  initial begin
    int n;
    @(posedge clk);
    wait (rst_n);
    forever begin
      if (hold_long) begin
        out_word.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_long = 1'b0;
      end
      out_word.ready <= 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_word.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_word(logic [19:0] ut, logic [19:0] up);
    int g;
    g = rand_in ? gap_len() : 0;
    if (g > 0) begin
      in_word.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_word.valid <= 1'b1;
    in_word.raw_temperature <= ut;
    in_word.raw_pressure <= up;
    @(posedge clk);
    while (!in_word.ready) @(posedge clk);
    sb.note_input(ut, up);
  endtask

  task automatic drain();
    in_word.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic write_coef(logic [1:0] idx, logic [47:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_coef(idx, v);
    @(posedge clk);
  endtask

  function automatic logic [47:0] rnd48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // plausible calibration set with random content
  task automatic load_typical();
    write_coef(RegTemp, {16'($urandom_range(0, 3000) - 1500), 16'($urandom_range(26000, 27500)),
                         16'($urandom_range(27000, 28500))});
    write_coef(RegPres1, {16'($urandom_range(0, 8000) - 4000),
                          16'(-$urandom_range(10000, 11000)), 16'($urandom_range(36000, 37500))});
    write_coef(RegPres2, {16'($urandom_range(0, 200) - 100), 16'($urandom_range(0, 300)),
                          16'($urandom_range(2500, 3000))});
    write_coef(RegPres3, {16'($urandom_range(0, 6000) - 3000), 16'(-$urandom_range(6000, 8000)),
                          16'($urandom_range(0, 30) - 15)});
  endtask

  task automatic load_random();
    write_coef(RegTemp, rnd48());
    write_coef(RegPres1, rnd48());
    write_coef(RegPres2, rnd48());
    write_coef(RegPres3, rnd48());
  endtask

  task automatic send_random(int n, bit near);
    for (int i = 0; i < n; i++) begin
      if (near && $urandom_range(0, 3) != 0)
        send_word(20'($urandom_range(400000, 600000)), 20'($urandom_range(300000, 500000)));
      else
        send_word(20'($urandom), 20'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients: divisor zero
    send_word(20'd0, 20'd0);
    send_word(20'hFFFFF, 20'hFFFFF);
    drain();

    write_coef(RegTemp, {16'd50, 16'd26435, 16'd27504});
    write_coef(RegPres1, {16'hFFF9, 16'hD5D0, 16'd36477});
    write_coef(RegPres2, {16'hFFF9, 16'd140, 16'd2855});
    write_coef(RegPres3, {16'd6000, 16'hC4D0, 16'd15500});
    send_word(20'd519888, 20'd415148);
    send_word(20'd0, 20'd0);
    send_word(20'hFFFFF, 20'hFFFFF);
    send_word(20'd0, 20'hFFFFF);
    send_word(20'hFFFFF, 20'd0);
    send_word(20'h55555, 20'hAAAAA);
    send_word(20'hAAAAA, 20'h55555);
    drain();

    // extremes of the coefficient words
    write_coef(RegTemp, '1);
    write_coef(RegPres1, '1);
    write_coef(RegPres2, '1);
    write_coef(RegPres3, '1);
    send_word(20'd0, 20'd0);
    send_word(20'hFFFFF, 20'hFFFFF);
    send_word(20'h80000, 20'h7FFFF);
    drain();
    write_coef(RegTemp, 48'h8000_8000_FFFF);
    write_coef(RegPres1, 48'h8000_7FFF_0001);
    write_coef(RegPres2, 48'h7FFF_8000_7FFF);
    write_coef(RegPres3, 48'h8000_7FFF_8000);
    send_word(20'd0, 20'hFFFFF);
    send_word(20'hFFFFF, 20'd0);
    send_word(20'h12345, 20'h6789A);
    // p1 zero gives zero divisor with live temperature
    drain();
    write_coef(RegPres1, 48'h1234_5678_0000);
    send_word(20'd519888, 20'd415148);
    send_word(20'h7FFFF, 20'h80000);
    drain();

    // long receiver stall fills the pipeline
    load_typical();
    hold_long = 1'b1;
    rand_in = 1'b0;
    send_random(120, 1'b1);
    rand_in = 1'b1;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) load_random();
      else load_typical();
      send_random(95, 1'b1);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("temp_pressure_compensation_tb: clean");
    end else begin
      $display("temp_pressure_compensation_tb: errors");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("temp_pressure_compensation_tb: errors");
    $finish;
  end

endmodule
